[hw/rtl/trd_pkg.sv]
// Shared types and constants of the TGA run-length pixel decoder.
`timescale 1ns / 1ps

package trd_pkg;

    localparam int BYTE_W       = 8;
    localparam int PIXEL_W      = 32;
    localparam int BPP_W        = 3;
    localparam int IDX_W        = 2;
    localparam int REM_W        = 7;
    localparam int CNT_W        = 8;
    localparam int VCNT_W       = 2;
    localparam int IMG_W        = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 1;
    localparam int FIFO_DEPTH   = 2;
    localparam int FIFO_PTR_W   = 1;
    localparam int FIFO_CNT_W   = 2;

    localparam logic [BPP_W-1:0] MAX_BYTES_PER_PIXEL = 3'd4;
    localparam logic [BPP_W-1:0] BPP_RESET           = 3'd4;
    localparam logic [IMG_W-1:0] IMG_RESET           = 32'd1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_PIXELS    = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_RAW    = 2'd1,
        PH_RUN    = 2'd2
    } trd_phase_t;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_DONE    = 2'd1,
        ST_ERROR   = 2'd2
    } trd_status_t;

    // One command from the front: count copies of pixel, then status.
    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic [CNT_W-1:0]   count;
        trd_status_t        status;
    } trd_cmd_t;

endpackage

[hw/rtl/trd_front.sv]
// Front end: packet parsing, pixel assembly, image accounting and config registers.
`timescale 1ns / 1ps

module trd_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [trd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            accept,
    input  logic [trd_pkg::BYTE_W-1:0]      stream_byte,
    input  logic                            image_start,
    output trd_pkg::trd_cmd_t               cmd
);

    logic [trd_pkg::BPP_W-1:0]   bpp_reg;
    logic [trd_pkg::IMG_W-1:0]   img_reg;

    trd_pkg::trd_phase_t         phase_reg, phase_next;
    logic [trd_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [trd_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [trd_pkg::PIXEL_W-1:0] asm_reg, asm_next;
    logic [trd_pkg::IMG_W-1:0]   done_reg, done_next;
    trd_pkg::trd_status_t        fin_reg, fin_next;

    // State as seen by this byte: image_start clears it first.
    trd_pkg::trd_phase_t         cur_phase;
    logic [trd_pkg::REM_W-1:0]   cur_rem;
    logic [trd_pkg::IDX_W-1:0]   cur_idx;
    logic [trd_pkg::PIXEL_W-1:0] cur_asm;
    logic [trd_pkg::IMG_W-1:0]   cur_done;
    trd_pkg::trd_status_t        cur_fin;

    logic [trd_pkg::BPP_W-1:0]   bpp_eff;
    logic                        last_byte;
    logic [trd_pkg::PIXEL_W-1:0] asm_new;
    logic                        img_full;
    logic [trd_pkg::IMG_W-1:0]   room;
    logic [trd_pkg::CNT_W-1:0]   run_n;
    logic                        run_over;
    logic [trd_pkg::CNT_W-1:0]   run_emit;

    assign cur_phase = image_start ? trd_pkg::PH_HEADER  : phase_reg;
    assign cur_rem   = image_start ? '0                   : rem_reg;
    assign cur_idx   = image_start ? '0                   : idx_reg;
    assign cur_asm   = image_start ? '0                   : asm_reg;
    assign cur_done  = image_start ? '0                   : done_reg;
    assign cur_fin   = image_start ? trd_pkg::ST_RUNNING : fin_reg;

    always_comb
    begin
        if (bpp_reg == '0)
            bpp_eff = 3'd1;
        else if (bpp_reg > trd_pkg::MAX_BYTES_PER_PIXEL)
            bpp_eff = trd_pkg::MAX_BYTES_PER_PIXEL;
        else
            bpp_eff = bpp_reg;
    end

    assign last_byte = ({1'b0, cur_idx} + 3'd1) >= bpp_eff;
    assign asm_new   = cur_asm | ({24'd0, stream_byte} << {cur_idx, 3'b000});
    assign img_full  = cur_done >= img_reg;
    assign room      = img_reg - cur_done;
    assign run_n     = {1'b0, cur_rem} + 8'd1;
    assign run_over  = img_full || (room < {24'd0, run_n});
    // Room is below the run length here, so it fits the count field.
    assign run_emit  = img_full ? '0 : (run_over ? room[trd_pkg::CNT_W-1:0] : run_n);

    // Next state.
    always_comb
    begin
        phase_next = cur_phase;
        rem_next   = cur_rem;
        idx_next   = cur_idx;
        asm_next   = cur_asm;
        done_next  = cur_done;
        fin_next   = cur_fin;
        if (cur_fin == trd_pkg::ST_RUNNING)
        begin
            unique case (cur_phase)
                trd_pkg::PH_RAW, trd_pkg::PH_RUN:
                begin
                    if (!last_byte)
                    begin
                        idx_next = cur_idx + 2'd1;
                        asm_next = asm_new;
                    end
                    else
                    begin
                        idx_next = '0;
                        asm_next = '0;
                        if (cur_phase == trd_pkg::PH_RAW)
                        begin
                            if (img_full)
                                fin_next = trd_pkg::ST_ERROR;
                            else
                            begin
                                done_next = cur_done + 32'd1;
                                if (cur_rem == '0)
                                begin
                                    phase_next = trd_pkg::PH_HEADER;
                                    fin_next   = (room == 32'd1) ? trd_pkg::ST_DONE
                                                                 : trd_pkg::ST_RUNNING;
                                end
                                else
                                    rem_next = cur_rem - 7'd1;
                            end
                        end
                        else
                        begin
                            done_next = cur_done + {24'd0, run_emit};
                            if (run_over)
                                fin_next = trd_pkg::ST_ERROR;
                            else
                            begin
                                phase_next = trd_pkg::PH_HEADER;
                                rem_next   = '0;
                                fin_next   = (room == {24'd0, run_n}) ? trd_pkg::ST_DONE
                                                                      : trd_pkg::ST_RUNNING;
                            end
                        end
                    end
                end
                default:
                begin
                    // Packet header: both packet kinds keep the low seven bits.
                    idx_next   = '0;
                    asm_next   = '0;
                    phase_next = stream_byte[7] ? trd_pkg::PH_RUN : trd_pkg::PH_RAW;
                    rem_next   = stream_byte[trd_pkg::REM_W-1:0];
                end
            endcase
        end
    end

    // Command for the back end.
    always_comb
    begin
        cmd.pixel  = '0;
        cmd.count  = '0;
        cmd.status = fin_next;
        if (cur_fin == trd_pkg::ST_RUNNING && last_byte &&
            (cur_phase == trd_pkg::PH_RAW || cur_phase == trd_pkg::PH_RUN))
        begin
            cmd.pixel = asm_new;
            if (cur_phase == trd_pkg::PH_RAW)
                cmd.count = img_full ? 8'd0 : 8'd1;
            else
                cmd.count = run_emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg   <= trd_pkg::BPP_RESET;
            img_reg   <= trd_pkg::IMG_RESET;
            phase_reg <= trd_pkg::PH_HEADER;
            rem_reg   <= '0;
            idx_reg   <= '0;
            asm_reg   <= '0;
            done_reg  <= '0;
            fin_reg   <= trd_pkg::ST_RUNNING;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    trd_pkg::REG_BYTES_PER_PIXEL: bpp_reg <= cfg_data[trd_pkg::BPP_W-1:0];
                    trd_pkg::REG_IMAGE_PIXELS:    img_reg <= cfg_data;
                    default:                      ;
                endcase
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                rem_reg   <= rem_next;
                idx_reg   <= idx_next;
                asm_reg   <= asm_next;
                done_reg  <= done_next;
                fin_reg   <= fin_next;
            end
        end
    end

endmodule

[hw/rtl/trd_fifo.sv]
// Two-entry command queue between the front and back ends.
`timescale 1ns / 1ps

module trd_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  trd_pkg::trd_cmd_t wr_cmd,
    output logic              full,
    input  logic              rd_en,
    output trd_pkg::trd_cmd_t rd_cmd,
    output logic              empty
);

    trd_pkg::trd_cmd_t                entry_reg [trd_pkg::FIFO_DEPTH];
    logic [trd_pkg::FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [trd_pkg::FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [trd_pkg::FIFO_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                             do_wr;
    logic                             do_rd;

    assign full   = cnt_reg == trd_pkg::FIFO_CNT_W'(trd_pkg::FIFO_DEPTH);
    assign empty  = cnt_reg == '0;
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + 2'd1;
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

[hw/rtl/trd_back.sv]
// Back end: expands one command into pixel-pair results on the output side.
`timescale 1ns / 1ps

module trd_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  trd_pkg::trd_cmd_t                cmd,
    input  logic                             cmd_empty,
    output logic                             cmd_pop,
    input  logic                             pop,
    output logic                             empty,
    output logic [trd_pkg::PIXEL_W-1:0]      pixel_first,
    output logic [trd_pkg::PIXEL_W-1:0]      pixel_second,
    output logic [trd_pkg::VCNT_W-1:0]       pixel_valid_count,
    output logic                             last_of_run,
    output logic [1:0]                       status
);

    logic              cur_valid_reg, cur_valid_next;
    trd_pkg::trd_cmd_t cur_reg, cur_next;
    logic              load;
    logic              two_or_more;

    assign two_or_more = cur_reg.count >= 8'd2;
    assign last_of_run = cur_reg.count <= 8'd2;
    assign empty       = !cur_valid_reg;

    // Take the next command when idle or when the final result leaves.
    assign load    = !cur_valid_reg || (pop && last_of_run);
    assign cmd_pop = load && !cmd_empty;

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        if (load)
        begin
            cur_valid_next = !cmd_empty;
            cur_next       = cmd;
        end
        else if (pop)
            cur_next.count = cur_reg.count - 8'd2;
    end

    assign pixel_first       = (cur_reg.count != '0) ? cur_reg.pixel : '0;
    assign pixel_second      = two_or_more ? cur_reg.pixel : '0;
    assign pixel_valid_count = two_or_more ? 2'd2 : cur_reg.count[trd_pkg::VCNT_W-1:0];
    assign status            = last_of_run ? cur_reg.status : trd_pkg::ST_RUNNING;

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_valid_reg <= 1'b0;
        else
            cur_valid_reg <= cur_valid_next;
    end

endmodule

[hw/rtl/tga_rle_pixel_decoder_top.sv]
// Top level of the TGA run-length pixel decoder.
`timescale 1ns / 1ps

// Decodes a Targa run-length coded pixel stream, one byte per request on the
// push side. A header byte below 128 opens a raw packet of header+1 literal
// pixels; 128 or more opens a run that repeats the following pixel
// header-127 times. Pixels are bytes_per_pixel bytes (register 0, 0 acts as
// 1, above 4 acts as 4), first byte in the low byte, unused bytes zero.
// Every accepted byte yields at least one result request on the pop side;
// pixels go out two to a request and last_of_run marks the final request of
// a byte. status on that final request reads 1 once the pixel count reaches
// image_pixels (register 1) at a packet end, 2 if a packet would overrun the
// image (the excess pixels are dropped); both stick until a byte arrives
// with image_start high, which clears the decode state before that byte.
// Timing: the front end takes one byte per cycle while full is low, passes
// one command per byte into a two-entry queue; the back end turns a command
// into results at one request per cycle while pop is high, so a run of n
// pixels takes ceil(n/2) requests (up to 64), and push sees full once two
// commands wait behind it. A result passes through the queue and the back
// end's command register before it reaches the pop side.
// Write configuration only while the block is idle.
module tga_rle_pixel_decoder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [trd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [trd_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            push,
    output logic                            full,
    input  logic [trd_pkg::BYTE_W-1:0]      stream_byte,
    input  logic                            image_start,
    output logic                            empty,
    input  logic                            pop,
    output logic [trd_pkg::PIXEL_W-1:0]     pixel_first,
    output logic [trd_pkg::PIXEL_W-1:0]     pixel_second,
    output logic [trd_pkg::VCNT_W-1:0]      pixel_valid_count,
    output logic                            last_of_run,
    output logic [1:0]                      status
);

    trd_pkg::trd_cmd_t front_cmd;
    trd_pkg::trd_cmd_t queue_cmd;
    logic              accept;
    logic              queue_empty;
    logic              queue_pop;

    // A byte is taken whenever the command queue has room.
    assign accept = push && !full;

    trd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .stream_byte (stream_byte),
        .image_start (image_start),
        .cmd         (front_cmd)
    );

    trd_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_cmd (front_cmd),
        .full   (full),
        .rd_en  (queue_pop),
        .rd_cmd (queue_cmd),
        .empty  (queue_empty)
    );

    trd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (queue_cmd),
        .cmd_empty         (queue_empty),
        .cmd_pop           (queue_pop),
        .pop               (pop),
        .empty             (empty),
        .pixel_first       (pixel_first),
        .pixel_second      (pixel_second),
        .pixel_valid_count (pixel_valid_count),
        .last_of_run       (last_of_run),
        .status            (status)
    );

endmodule

[hw/rtl/trd_checker.sv]
// Port-level checks for the TGA run-length pixel decoder, bound to the top level.
`timescale 1ns / 1ps

module trd_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            empty,
    input logic                            pop,
    input logic [trd_pkg::PIXEL_W-1:0]     pixel_first,
    input logic [trd_pkg::PIXEL_W-1:0]     pixel_second,
    input logic [trd_pkg::VCNT_W-1:0]      pixel_valid_count,
    input logic                            last_of_run,
    input logic [1:0]                      status
);

    // A finished status only rides on the final request of a byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status != 2'd0 |-> last_of_run)
    else $error("status reported on a non-final result");

    // Pixel fields that carry no pixel read zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pixel_valid_count == 2'd0 |-> pixel_first == '0 && pixel_second == '0)
    else $error("empty result carries pixel data");

    // A run continues at once with the same pixel after a non-final request.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !last_of_run |=> !empty && pixel_first == $past(pixel_first))
    else $error("run expansion broke off or changed pixel");

    // A non-final request always carries a full pair.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !last_of_run |-> pixel_valid_count == 2'd2)
    else $error("short pixel pair before the end of a run");

    // A waiting result holds until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(pixel_first) && $stable(status))
    else $error("waiting result changed");

endmodule

bind tga_rle_pixel_decoder_top trd_checker u_trd_checker (.*);

[tb/tga_rle_pixel_decoder_top_tb.sv]
// Self-checking testbench for the TGA run-length pixel decoder top level.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_top_tb;

    // Clock period, reset length and run limits.
    localparam int          CLK_HALF     = 6;
    localparam int          RESET_CYCLES = 10;
    // A result lags its byte through the queue; leave margin before config writes.
    localparam int          DRAIN_CYCLES = 6;
    // Worst case: ~300 bytes, 64 pair requests each, receiver stalling most cycles,
    // taken several times over.
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          REPORT_MAX   = 10;
    // Header bytes at or above this value open a run packet.
    localparam logic [7:0]  RUN_FLAG     = 8'd128;
    localparam int          MAX_PACKET   = 128;

    // One pop-side request: up to two pixels plus the per-byte flags.
    typedef struct packed {
        logic [trd_pkg::PIXEL_W-1:0] px_a;
        logic [trd_pkg::PIXEL_W-1:0] px_b;
        logic [trd_pkg::VCNT_W-1:0]  count;
        logic                        tail;
        logic [1:0]                  status;
    } pixel_pair_t;

    // DUT ports.
    logic                               clk;
    logic                               rst_n;
    logic                               cfg_write;
    logic [trd_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [trd_pkg::CFG_DATA_W-1:0]     cfg_data;
    logic                               push;
    logic                               full;
    logic [trd_pkg::BYTE_W-1:0]         stream_byte;
    logic                               image_start;
    logic                               empty;
    logic                               pop;
    logic [trd_pkg::PIXEL_W-1:0]        pixel_first;
    logic [trd_pkg::PIXEL_W-1:0]        pixel_second;
    logic [trd_pkg::VCNT_W-1:0]         pixel_valid_count;
    logic                               last_of_run;
    logic [1:0]                         status;

    // Decoder mirror: configuration registers and decode state.
    logic [trd_pkg::BPP_W-1:0]          bpp_reg;
    logic [trd_pkg::IMG_W-1:0]          image_px_reg;
    trd_pkg::trd_phase_t                phase;
    logic [7:0]                         pkt_left;
    logic [trd_pkg::IDX_W-1:0]          byte_idx;
    logic [trd_pkg::PIXEL_W-1:0]        px_build;
    logic [trd_pkg::IMG_W-1:0]          px_count;
    trd_pkg::trd_status_t               img_state;

    // Pixels decoded from the current byte, and pair requests still owed by the DUT.
    logic [trd_pkg::PIXEL_W-1:0]        decoded_px[$];
    pixel_pair_t                        pending_pairs[$];

    int                     send_idle_pct;
    int                     recv_idle_pct;
    int                     bytes_sent;
    int                     mismatches;
    int                     cycle_count;

    tga_rle_pixel_decoder_top DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .push              (push),
        .full              (full),
        .stream_byte       (stream_byte),
        .image_start       (image_start),
        .empty             (empty),
        .pop               (pop),
        .pixel_first       (pixel_first),
        .pixel_second      (pixel_second),
        .pixel_valid_count (pixel_valid_count),
        .last_of_run       (last_of_run),
        .status            (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Decoder mirror
    // ------------------------------------------------------------------

    // Clamp the pixel size register: 0 acts as 1, anything above 4 acts as 4.
    function automatic int eff_bpp();
        if (bpp_reg == 0)
            return 1;
        if (bpp_reg > trd_pkg::MAX_BYTES_PER_PIXEL)
            return trd_pkg::MAX_BYTES_PER_PIXEL;
        return bpp_reg;
    endfunction

    function automatic void clear_image();
        phase     = trd_pkg::PH_HEADER;
        pkt_left  = '0;
        byte_idx  = '0;
        px_build  = '0;
        px_count  = '0;
        img_state = trd_pkg::ST_RUNNING;
    endfunction

    // Add one byte to the pixel under assembly; return 1 once it is complete.
    // A byte index already past a freshly shrunk pixel size completes at once.
    function automatic bit take_byte(input logic [7:0] b,
                                     output logic [trd_pkg::PIXEL_W-1:0] px);
        int idx;
        idx = byte_idx;
        px = '0;
        px_build = px_build | (trd_pkg::PIXEL_W'(b) << (8 * idx));
        if (idx + 1 >= eff_bpp())
        begin
            px       = px_build;
            px_build = '0;
            byte_idx = '0;
            return 1'b1;
        end
        byte_idx = trd_pkg::IDX_W'(idx + 1);
        return 1'b0;
    endfunction

    // Emit a pixel unless the image is already full; a full image turns the
    // pixel into an overrun error and stops decoding.
    function automatic bit emit_pixel(input logic [trd_pkg::PIXEL_W-1:0] px);
        if (px_count >= image_px_reg)
        begin
            img_state = trd_pkg::ST_ERROR;
            return 1'b0;
        end
        decoded_px.push_back(px);
        px_count = px_count + 1;
        return 1'b1;
    endfunction

    function automatic void end_packet();
        phase    = trd_pkg::PH_HEADER;
        pkt_left = '0;
        if (img_state == trd_pkg::ST_RUNNING && px_count >= image_px_reg)
            img_state = trd_pkg::ST_DONE;
    endfunction

    // Work out the pair requests that one accepted byte causes.
    task automatic predict_decode(input logic [7:0] b, input logic st);
        logic [trd_pkg::PIXEL_W-1:0] px;
        pixel_pair_t                 pair;
        int                          n_res;
        int                          n_px;
        int                          base;
        bit                          ok;
        if (st)
            clear_image();
        decoded_px.delete();
        if (img_state == trd_pkg::ST_RUNNING)
        begin
            case (phase)
                trd_pkg::PH_RAW:
                begin
                    if (take_byte(b, px) && emit_pixel(px))
                    begin
                        if (pkt_left == 0)
                            end_packet();
                        else
                            pkt_left = pkt_left - 1;
                    end
                end
                trd_pkg::PH_RUN:
                begin
                    if (take_byte(b, px))
                    begin
                        ok = 1'b1;
                        for (int k = 0; k <= pkt_left && ok; k++)
                            ok = emit_pixel(px);
                        if (ok)
                            end_packet();
                    end
                end
                default:
                begin
                    // Packet header; an unknown phase code also lands here.
                    byte_idx = '0;
                    px_build = '0;
                    if (b < RUN_FLAG)
                    begin
                        phase    = trd_pkg::PH_RAW;
                        pkt_left = b;
                    end
                    else
                    begin
                        phase    = trd_pkg::PH_RUN;
                        pkt_left = b - RUN_FLAG;
                    end
                end
            endcase
        end
        // Pack pixels two to a request; a byte with no pixel still yields one
        // empty request carrying the status.
        n_px  = decoded_px.size();
        n_res = (n_px + 1) / 2;
        if (n_res == 0)
            n_res = 1;
        for (int r = 0; r < n_res; r++)
        begin
            base = 2 * r;
            pair = '0;
            if (base < n_px)
                pair.px_a = decoded_px[base];
            if (base + 1 < n_px)
                pair.px_b = decoded_px[base + 1];
            pair.count  = (n_px - base >= 2) ? 2'd2 : ((n_px > base) ? 2'd1 : 2'd0);
            pair.tail   = (r == n_res - 1);
            pair.status = pair.tail ? img_state : trd_pkg::ST_RUNNING;
            pending_pairs.push_back(pair);
        end
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Offer one byte; idle at random before raising push, then hold the request
    // until full is low at a rising edge.
    task automatic send_byte(input logic [7:0] b, input logic st);
        bit accepted;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            if ($urandom_range(99) < send_idle_pct)
            begin
                push <= 1'b0;
                stream_byte <= trd_pkg::BYTE_W'($urandom);
                image_start <= 1'($urandom);
            end
            else
            begin
                push        <= 1'b1;
                stream_byte <= b;
                image_start <= st;
                @(posedge clk);
                while (full)
                    @(posedge clk);
                accepted = 1'b1;
            end
        end
        bytes_sent++;
        predict_decode(b, st);
    endtask

    // Write one configuration register and mirror it at the same edge.
    task automatic write_reg(input logic [trd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [trd_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == trd_pkg::REG_BYTES_PER_PIXEL)
            bpp_reg = value[trd_pkg::BPP_W-1:0];
        else
            image_px_reg = value;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Drop push and hold until every owed request has drained.
    task automatic wait_idle();
        @(negedge clk);
        push <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Receiver: stall at random, decided at each falling edge.
    always @(negedge clk)
        pop <= ($urandom_range(99) >= recv_idle_pct);

    // ------------------------------------------------------------------
    // Checker
    // ------------------------------------------------------------------

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s", $time, what);
    endtask

    // Compare every accepted request with the oldest owed one.
    always @(posedge clk)
    begin : check_result
        pixel_pair_t got;
        pixel_pair_t want;
        if (rst_n && pop && !empty)
        begin
            got = {pixel_first, pixel_second, pixel_valid_count, last_of_run, status};
            if (pending_pairs.size() == 0)
            begin
                note_mismatch($sformatf(
                    "unexpected request: a=%h b=%h cnt=%0d last=%0d st=%0d",
                    got.px_a, got.px_b, got.count, got.tail, got.status));
            end
            else
            begin
                want = pending_pairs.pop_front();
                if (got !== want)
                    note_mismatch($sformatf({
                        "request mismatch: exp a=%h b=%h cnt=%0d last=%0d st=%0d, ",
                        "got a=%h b=%h cnt=%0d last=%0d st=%0d"},
                        want.px_a, want.px_b, want.count, want.tail, want.status,
                        got.px_a, got.px_b, got.count, got.tail, got.status));
            end
        end
    end

    // Hard stop if the run hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tga_rle_pixel_decoder_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: 4 bytes per pixel, one-pixel image. Decode a single raw
    // pixel without image_start, then check that a later byte is ignored.
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    // Longest run (128 copies, 64 requests) into the largest image, then a
    // short raw packet with extreme byte values.
    task automatic test_long_run();
        wait_idle();
        write_reg(trd_pkg::REG_BYTES_PER_PIXEL, 32'd1);
        write_reg(trd_pkg::REG_IMAGE_PIXELS, 32'hFFFF_FFFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // Run packet longer than the image: emit up to the image size, drop the
    // rest, raise the error, then ignore the next byte.
    task automatic test_overrun();
        wait_idle();
        write_reg(trd_pkg::REG_BYTES_PER_PIXEL, 32'd2);
        write_reg(trd_pkg::REG_IMAGE_PIXELS, 32'd3);
        send_byte(8'h84, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'h00, 1'b0);
    endtask

    // Empty image: the very first pixel overruns. Size 0 acts as one byte.
    task automatic test_zero_image();
        wait_idle();
        write_reg(trd_pkg::REG_BYTES_PER_PIXEL, 32'd0);
        write_reg(trd_pkg::REG_IMAGE_PIXELS, 32'd0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h7E, 1'b0);
    endtask

    // Oversized pixel setting clamps to 4; shrinking the size mid-pixel
    // completes the pixel on the next byte; finish the image at 3 bytes.
    task automatic test_pixel_size_change();
        wait_idle();
        write_reg(trd_pkg::REG_BYTES_PER_PIXEL, 32'd7);
        write_reg(trd_pkg::REG_IMAGE_PIXELS, 32'd2);
        send_byte(8'h01, 1'b1);
        send_byte(8'hC1, 1'b0);
        send_byte(8'hC2, 1'b0);
        send_byte(8'hC3, 1'b0);
        wait_idle();
        write_reg(trd_pkg::REG_BYTES_PER_PIXEL, 32'd2);
        send_byte(8'hC4, 1'b0);
        wait_idle();
        write_reg(trd_pkg::REG_BYTES_PER_PIXEL, 32'd3);
        send_byte(8'hD1, 1'b0);
        send_byte(8'hD2, 1'b0);
        send_byte(8'hD3, 1'b0);
    endtask

    // One coded image with random content under the current settings: mostly
    // well-formed packets, some overrunning or cut short, some pure noise.
    // Stop opening packets once the byte count reaches stop_at.
    task automatic send_random_image(input int stop_at);
        int         left;
        int         maxn;
        int         n;
        int         bpp;
        int         packets;
        bit         raw;
        logic       st;
        bpp = eff_bpp();
        if ($urandom_range(7) == 0)
        begin
            // Noise: random bytes with random image_start.
            repeat ($urandom_range(10, 3))
                send_byte(trd_pkg::BYTE_W'($urandom), 1'($urandom));
            return;
        end
        if (image_px_reg == 0)
            left = 1;
        else if (image_px_reg > 200)
            left = 200;
        else
            left = image_px_reg;
        st = 1'b1;
        packets = 0;
        while (left > 0 && packets < 10 && bytes_sent < stop_at)
        begin
            raw  = 1'($urandom);
            maxn = (left < MAX_PACKET) ? left : MAX_PACKET;
            if ($urandom_range(9) == 0)
                n = left + $urandom_range(3, 1);
            else if (raw)
                n = $urandom_range((maxn < 8) ? maxn : 8, 1);
            else if ($urandom_range(3) == 0)
                n = $urandom_range(maxn, 1);
            else
                n = $urandom_range((maxn < 6) ? maxn : 6, 1);
            if (n > MAX_PACKET)
                n = MAX_PACKET;
            send_byte(raw ? 8'(n - 1) : 8'(n - 1) | RUN_FLAG, st);
            st = 1'b0;
            // Cut a packet short now and then; the next image_start recovers.
            if ($urandom_range(19) == 0)
            begin
                repeat ($urandom_range(bpp, 0))
                    send_byte(trd_pkg::BYTE_W'($urandom), 1'b0);
                return;
            end
            repeat (raw ? n * bpp : bpp)
                send_byte(trd_pkg::BYTE_W'($urandom), 1'b0);
            left = (n > left) ? 0 : left - n;
            packets++;
        end
        // Trailing byte after the image ends: ignored by the block.
        if ($urandom_range(3) == 0)
            send_byte(trd_pkg::BYTE_W'($urandom), 1'b0);
    endtask

    // Random images under changing settings until the byte quota is met.
    task automatic test_random_images(input int send_pct, input int recv_pct, input int quota);
        int first_byte;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < quota)
        begin
            wait_idle();
            if ($urandom_range(3) == 0)
                write_reg(trd_pkg::REG_BYTES_PER_PIXEL,
                          trd_pkg::CFG_DATA_W'($urandom_range(7)));
            else
                write_reg(trd_pkg::REG_BYTES_PER_PIXEL,
                          trd_pkg::CFG_DATA_W'($urandom_range(4, 1)));
            case ($urandom_range(9))
                0:       write_reg(trd_pkg::REG_IMAGE_PIXELS, 32'd0);
                1:       write_reg(trd_pkg::REG_IMAGE_PIXELS,
                                   trd_pkg::CFG_DATA_W'($urandom));
                2:       write_reg(trd_pkg::REG_IMAGE_PIXELS, 32'hFFFF_FFFF);
                default: write_reg(trd_pkg::REG_IMAGE_PIXELS,
                                   trd_pkg::CFG_DATA_W'($urandom_range(24, 1)));
            endcase
            repeat ($urandom_range(3, 1))
            begin
                if (bytes_sent - first_byte < quota)
                    send_random_image(first_byte + quota);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        // Drive every input to a known value and hold reset.
        rst_n       = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        stream_byte = '0;
        image_start = 1'b0;
        cfg_write   = 1'b0;
        cfg_index   = trd_pkg::REG_BYTES_PER_PIXEL;
        cfg_data    = '0;
        bytes_sent  = 0;
        mismatches  = 0;
        cycle_count = 0;
        bpp_reg      = trd_pkg::BPP_RESET;
        image_px_reg = trd_pkg::IMG_RESET;
        clear_image();
        send_idle_pct = 29;
        recv_idle_pct = 72;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed checks, sender lightly idle and receiver heavily stalled.
        test_reset_defaults();
        test_long_run();
        test_overrun();
        test_zero_image();
        test_pixel_size_change();

        // Random images: swap the idle mix, then run back to back.
        test_random_images(29, 72, 75);
        test_random_images(72, 29, 75);
        test_random_images(0, 0, 75);

        // Let everything owed drain, then give the verdict.
        wait_idle();
        if (mismatches == 0 && pending_pairs.size() == 0)
            $display("tga_rle_pixel_decoder_top verification clean");
        else
            $display("tga_rle_pixel_decoder_top verification failed");
        $finish;
    end

endmodule
